@@ hdl/lfsr_trace_message_checker_core_macros.svh @@
// assertion macros used by the checker back end (ltmc_back)
`ifndef LFSR_TRACE_MESSAGE_CHECKER_CORE_MACROS_SVH
`define LFSR_TRACE_MESSAGE_CHECKER_CORE_MACROS_SVH

// same-cycle implication
`define LTMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ltmc assertion failed");

// next-cycle implication
`define LTMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ltmc assertion failed");

`endif

@@ hdl/ltmc_pkg.sv @@
`default_nettype none
package ltmc_pkg;

  localparam logic [31:0] LFSR_TAPS   = 32'h1090_4081;
  localparam logic [31:0] SEED_RESET  = 32'hFF00_FF00;
  localparam logic [7:0]  LIMIT_RESET = 8'd10;
  localparam logic [8:0]  ERR_MAX     = 9'd256;

  localparam logic [2:0]  POS_FIRST = 3'd0;
  localparam logic [2:0]  POS_LAST  = 3'd4;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0]  channel;
    logic [31:0] payload;
  } msg_t;

  typedef struct packed {
    logic [31:0] message_index;
    logic        mismatch;
    logic [7:0]  received_channel;
    logic [31:0] received_payload;
    logic [7:0]  expected_channel;
    logic [31:0] expected_payload;
    logic [8:0]  error_total;
    logic        halted;
  } result_t;

  function automatic logic [31:0] lfsr_next(input logic [31:0] v);
    return {v[30:0], 1'b0} ^ (v[31] ? LFSR_TAPS : 32'h0);
  endfunction

endpackage
`default_nettype wire

@@ hdl/ltmc_front.sv @@
`default_nettype none
module ltmc_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [7:0]        in_data_byte,
  output logic              push_valid,
  input  wire               push_ready,
  output ltmc_pkg::msg_t    push_msg
);
  import ltmc_pkg::*;

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  chan_r, chan_nxt;
  logic [23:0] buf_r, buf_nxt;
  logic        accept;

  assign in_ready         = (pos_r != POS_LAST) || push_ready;
  assign push_valid       = in_valid && (pos_r == POS_LAST);
  assign push_msg.channel = chan_r;
  assign push_msg.payload = {in_data_byte, buf_r};
  assign accept           = in_valid && in_ready;

  always_comb begin
    pos_nxt  = pos_r;
    chan_nxt = chan_r;
    buf_nxt  = buf_r;
    if (accept) begin
      unique case (pos_r)
        3'd0: begin
          chan_nxt = in_data_byte;
          pos_nxt  = 3'd1;
        end
        3'd1: begin
          buf_nxt[7:0] = in_data_byte;
          pos_nxt      = 3'd2;
        end
        3'd2: begin
          buf_nxt[15:8] = in_data_byte;
          pos_nxt       = 3'd3;
        end
        3'd3: begin
          buf_nxt[23:16] = in_data_byte;
          pos_nxt        = POS_LAST;
        end
        default: begin
          pos_nxt = POS_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_FIRST;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chan_r <= chan_nxt;
    buf_r  <= buf_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/ltmc_queue.sv @@
`default_nettype none
module ltmc_queue #(
  parameter int unsigned DEPTH = ltmc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push_valid,
  output logic              push_ready,
  input  ltmc_pkg::msg_t    push_msg,
  output logic              pop_valid,
  input  wire               pop_ready,
  output ltmc_pkg::msg_t    pop_msg
);
  import ltmc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  msg_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_msg    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_msg;
    end
  end

endmodule
`default_nettype wire

@@ hdl/ltmc_back.sv @@
`default_nettype none
`include "lfsr_trace_message_checker_core_macros.svh"
module ltmc_back (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_take,
  input  wire                                  pop_valid,
  output logic                                 pop_ready,
  input  ltmc_pkg::msg_t                       pop_msg,
  input  wire                                  cfg_we,
  input  wire  [ltmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [ltmc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output ltmc_pkg::result_t                    out_res
);
  import ltmc_pkg::*;

  logic [31:0] gen_r, gen_nxt;
  logic [7:0]  exp_chan_r, exp_chan_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [8:0]  err_r, err_nxt;
  logic [7:0]  limit_r, limit_nxt;
  logic        stopped_r, stopped_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;

  logic        over, drop, take, check, group_start, bad, halt_now;
  logic [31:0] g1, g2;
  logic [7:0]  exp_chan;
  logic [8:0]  err_inc;

  assign over      = err_r > {1'b0, limit_r};
  assign drop      = stopped_r || over;
  assign pop_ready = drop || !out_valid_r || out_ready;
  assign take      = pop_valid && pop_ready;
  assign check     = take && !drop;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    group_start = (cnt_r[1:0] == 2'b00);
    g1          = group_start ? lfsr_next(gen_r) : gen_r;
    exp_chan    = group_start ? g1[7:0] : exp_chan_r;
    g2          = lfsr_next(g1);
    bad         = (pop_msg.channel != exp_chan) || (pop_msg.payload != g2);
    err_inc     = err_r + {8'd0, bad};
    halt_now    = bad && (err_inc > {1'b0, limit_r});
  end

  always_comb begin
    gen_nxt       = gen_r;
    exp_chan_nxt  = exp_chan_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    limit_nxt     = limit_r;
    stopped_nxt   = stopped_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    // any byte taken while over the limit halts, even inside a partial message
    if ((take && drop) || (in_take && over)) begin
      stopped_nxt = 1'b1;
    end
    if (check) begin
      gen_nxt       = g2;
      exp_chan_nxt  = exp_chan;
      cnt_nxt       = cnt_r + 32'd1;
      err_nxt       = err_inc;
      stopped_nxt   = stopped_r || halt_now;
      out_valid_nxt = 1'b1;
      res_nxt.message_index    = cnt_r + 32'd1;
      res_nxt.mismatch         = bad;
      res_nxt.received_channel = pop_msg.channel;
      res_nxt.received_payload = pop_msg.payload;
      res_nxt.expected_channel = exp_chan;
      res_nxt.expected_payload = g2;
      res_nxt.error_total      = err_inc;
      res_nxt.halted           = halt_now;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_we) begin
      if (cfg_index == CFG_IDX_SEED) begin
        gen_nxt = cfg_data[31:0];
      end else if (cfg_index == CFG_IDX_LIMIT) begin
        limit_nxt = cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= SEED_RESET;
      exp_chan_r  <= '0;
      cnt_r       <= '0;
      err_r       <= '0;
      limit_r     <= LIMIT_RESET;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      gen_r       <= gen_nxt;
      exp_chan_r  <= exp_chan_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      limit_r     <= limit_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // a halting result always carries an error
  `LTMC_ASSERT_NOW(a_halt_needs_mismatch, clk, rst_n, out_valid_r && res_r.halted, res_r.mismatch)
  // once stopped, no further result is produced
  `LTMC_ASSERT_NEXT(a_no_result_after_stop, clk, rst_n, stopped_r && !out_valid_r, !out_valid_r)
  // error count bounded by the largest limit plus one
  `LTMC_ASSERT_NOW(a_err_bounded, clk, rst_n, 1'b1, err_r <= ERR_MAX)

endmodule
`default_nettype wire

@@ hdl/lfsr_trace_message_checker_core.sv @@
`default_nettype none
// Byte-stream checker for 5-byte trace messages (channel byte, then a 32-bit
// little-endian payload) against a 32-bit Galois LFSR with taps 0x10904081.
// One byte is taken per clock unless the queue is full when a message's last
// byte arrives. The edge accepting that byte writes the message into the
// queue; once the output register is free or read, a later edge pops it through
// the checker into that register. The front assembler, queue and checker each
// stall independently, so an unread result does not block incoming bytes until
// the queue fills. Writing lfsr_seed reloads the generator; writes are expected
// only while no transaction is in flight. Once the error count exceeds
// error_limit (also when the limit is lowered below it and a byte follows),
// bytes are still accepted but discarded, and no results are produced until
// reset.
module lfsr_trace_message_checker_core #(
  parameter int unsigned QUEUE_DEPTH = ltmc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [31:0]                       out_message_index,
  output logic                              out_mismatch,
  output logic [7:0]                        out_received_channel,
  output logic [31:0]                       out_received_payload,
  output logic [7:0]                        out_expected_channel,
  output logic [31:0]                       out_expected_payload,
  output logic [8:0]                        out_error_total,
  output logic                              out_halted,
  input  wire                               cfg_we,
  input  wire  [ltmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [ltmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ltmc_pkg::*;

  logic    push_valid, push_ready;
  msg_t    push_msg;
  logic    pop_valid, pop_ready;
  msg_t    pop_msg;
  result_t res;
  logic    in_take;

  assign in_take = in_valid && in_ready;

  ltmc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_msg     (push_msg)
  );

  ltmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_msg   (push_msg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_msg    (pop_msg)
  );

  ltmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_msg   (pop_msg),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_message_index    = res.message_index;
  assign out_mismatch         = res.mismatch;
  assign out_received_channel = res.received_channel;
  assign out_received_payload = res.received_payload;
  assign out_expected_channel = res.expected_channel;
  assign out_expected_payload = res.expected_payload;
  assign out_error_total      = res.error_total;
  assign out_halted           = res.halted;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ltmc_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef enum {CORRUPT_NONE, CORRUPT_CHAN, CORRUPT_PAYLOAD} corrupt_e;
  typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_e;
  typedef enum {END_HALT_BY_ERROR, END_LIMIT_LOWERED} wrap_up_e;

  class lfsr_msg_tracker;
    logic [31:0] seed_reg;
    logic [7:0]  limit_reg;
    logic [2:0]  pos;
    logic [31:0] asm_word;
    logic [7:0]  chan_byte;
    logic [31:0] gen;
    logic [7:0]  exp_chan;
    logic [31:0] msg_count;
    logic [8:0]  err_count;
    bit          stopped;
    result_t     pending_results[$];
    logic [31:0] cur_index;
    int          fails;
    int          checked;

    function new();
      seed_reg  = SEED_RESET;
      limit_reg = LIMIT_RESET;
      pos       = '0;
      asm_word  = '0;
      chan_byte = '0;
      gen       = SEED_RESET;
      exp_chan  = '0;
      msg_count = '0;
      err_count = '0;
      stopped   = 1'b0;
      fails     = 0;
      checked   = 0;
    endfunction

    function logic [31:0] advance(logic [31:0] v);
      logic [31:0] s;
      s = v << 1;
      if (v[31]) s = s ^ LFSR_TAPS;
      return s;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      if (idx == CFG_IDX_SEED) begin
        seed_reg = v;
        gen = v;
      end else if (idx == CFG_IDX_LIMIT) begin
        limit_reg = v[7:0];
      end
    endfunction

    // channel and payload the block would accept as the next clean message
    function void next_good(output logic [7:0] c, output logic [31:0] p);
      logic [31:0] g;
      g = gen;
      c = exp_chan;
      if (msg_count[1:0] == 2'b00) begin
        g = advance(g);
        c = g[7:0];
      end
      p = advance(g);
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      logic [31:0] g;
      logic bad;
      if (err_count > {1'b0, limit_reg}) stopped = 1'b1;
      if (stopped) return;
      if (pos == 3'd0) begin
        chan_byte = b;
        asm_word = '0;
        pos = 3'd1;
        return;
      end
      asm_word = asm_word | ({24'b0, b} << (8 * (pos - 3'd1)));
      if (pos < 3'd4) begin
        pos = pos + 3'd1;
        return;
      end
      pos = 3'd0;
      g = gen;
      if (msg_count[1:0] == 2'b00) begin
        g = advance(g);
        exp_chan = g[7:0];
      end
      g = advance(g);
      gen = g;
      msg_count = msg_count + 32'd1;
      bad = (chan_byte != exp_chan) || (asm_word != g);
      r.halted = 1'b0;
      if (bad) begin
        err_count = err_count + 9'd1;
        if (err_count > {1'b0, limit_reg}) begin
          stopped = 1'b1;
          r.halted = 1'b1;
        end
      end
      r.message_index    = msg_count;
      r.mismatch         = bad;
      r.received_channel = chan_byte;
      r.received_payload = asm_word;
      r.expected_channel = exp_chan;
      r.expected_payload = g;
      r.error_total      = err_count;
      pending_results.push_back(r);
    endfunction

    function void note_fail(string s);
      fails++;
      if (fails <= 10) $display("MISMATCH: %s", s);
    endfunction

    function void cmp(string f, logic [31:0] want, logic [31:0] got);
      if (got !== want)
        note_fail($sformatf("message %0d %s: expected %h, got %h", cur_index, f, want, got));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        note_fail($sformatf("unexpected result with message_index %0d", got.message_index));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      cur_index = want.message_index;
      cmp("message_index", want.message_index, got.message_index);
      cmp("mismatch", 32'(want.mismatch), 32'(got.mismatch));
      cmp("received_channel", 32'(want.received_channel), 32'(got.received_channel));
      cmp("received_payload", want.received_payload, got.received_payload);
      cmp("expected_channel", 32'(want.expected_channel), 32'(got.expected_channel));
      cmp("expected_payload", want.expected_payload, got.expected_payload);
      cmp("error_total", 32'(want.error_total), 32'(got.error_total));
      cmp("halted", 32'(want.halted), 32'(got.halted));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_message_index;
  logic        out_mismatch;
  logic [7:0]  out_received_channel;
  logic [31:0] out_received_payload;
  logic [7:0]  out_expected_channel;
  logic [31:0] out_expected_payload;
  logic [8:0]  out_error_total;
  logic        out_halted;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IDX_SEED;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lfsr_msg_tracker tracker;
  int       burst_left = 0;
  int       n_bytes = 0;
  int       idle_cycles = 0;
  int       rx_cycle = 0;
  rx_mode_e rx_mode = RX_ALWAYS;

  lfsr_trace_message_checker_core i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_message_index    (out_message_index),
    .out_mismatch         (out_mismatch),
    .out_received_channel (out_received_channel),
    .out_received_payload (out_received_payload),
    .out_expected_channel (out_expected_channel),
    .out_expected_payload (out_expected_payload),
    .out_error_total      (out_error_total),
    .out_halted           (out_halted),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stall pattern, switches among four styles at random
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (rx_cycle % 8 == 0);
      default:   out_ready <= (rx_cycle % 16 < 10);
    endcase
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.message_index    = out_message_index;
      got.mismatch         = out_mismatch;
      got.received_channel = out_received_channel;
      got.received_payload = out_received_payload;
      got.expected_channel = out_expected_channel;
      got.expected_payload = out_expected_payload;
      got.error_total      = out_error_total;
      got.halted           = out_halted;
      tracker.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, tracker.pending_results.size());
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    tracker.note_byte(b);
    n_bytes++;
  endtask

  task automatic send_msg(input logic [7:0] c, input logic [31:0] p);
    send_byte(c);
    for (int i = 0; i < 4; i++) send_byte(p[8*i +: 8]);
  endtask

  task automatic send_good(input corrupt_e kind);
    logic [7:0] c;
    logic [31:0] p;
    tracker.next_good(c, p);
    case (kind)
      CORRUPT_CHAN:    c = c ^ (8'h01 << $urandom_range(0, 7));
      CORRUPT_PAYLOAD: p = p ^ (32'h1 << $urandom_range(0, 31));
      default: ;
    endcase
    send_msg(c, p);
  endtask

  // fill out a pending partial message with noise
  task automatic realign();
    while (tracker.pos != 3'd0 && !tracker.stopped) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] seed, input logic [7:0] lim);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_SEED;
    cfg_data <= seed;
    @(posedge clk);
    tracker.write_reg(CFG_IDX_SEED, seed);
    cfg_index <= CFG_IDX_LIMIT;
    cfg_data <= {24'b0, lim};
    @(posedge clk);
    tracker.write_reg(CFG_IDX_LIMIT, {24'b0, lim});
    cfg_we <= 1'b0;
  endtask

  initial begin
    int seg_bytes;
    int pick;
    int n;
    logic [31:0] seed;
    logic [7:0] lim;
    wrap_up_e wrap;
    corrupt_e kind;

    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, first message takes the extra step
    send_good(CORRUPT_NONE);
    settle();
    apply_settings(32'h0000_0000, 8'h00);
    send_good(CORRUPT_NONE);
    settle();
    apply_settings(32'hFFFF_FFFF, 8'hFF);
    send_msg(8'hFF, 32'hFFFF_FFFF);
    send_good(CORRUPT_CHAN);
    send_good(CORRUPT_PAYLOAD);
    // partial message left waiting across the next setting
    send_byte(8'h00);
    send_byte(8'hFF);

    for (int seg = 0; seg < 4; seg++) begin
      settle();
      seed = (seg == 1) ? 32'h8000_0000 : $urandom;
      lim = (seg == 0) ? 8'hFF : 8'($urandom_range(150, 255));
      apply_settings(seed, lim);
      seg_bytes = n_bytes;
      while (n_bytes - seg_bytes < 105) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          realign();
          kind = ($urandom_range(0, 9) < 8) ? CORRUPT_NONE : corrupt_e'($urandom_range(1, 2));
          send_good(kind);
        end else begin
          n = (pick < 9) ? $urandom_range(1, 4) : $urandom_range(1, 7);
          repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    settle();
    wrap = wrap_up_e'($urandom_range(0, 1));
    if (wrap == END_LIMIT_LOWERED) begin
      apply_settings($urandom, 8'h00);
    end else begin
      apply_settings($urandom, tracker.err_count[7:0]);
      realign();
      send_good(CORRUPT_PAYLOAD);
      send_good(CORRUPT_NONE);
    end
    // bytes after the halt are taken but produce nothing
    repeat (12) send_byte(8'($urandom_range(0, 255)));

    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d input bytes and %0d checked messages, %0d counted as errors",
             n_bytes, tracker.checked, tracker.err_count);
    $display("ending: %s, %0d field mismatches", wrap.name(), tracker.fails);
    if (tracker.fails == 0 && tracker.pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ltmc_pkg.sv
hdl/ltmc_front.sv
hdl/ltmc_queue.sv
hdl/ltmc_back.sv
hdl/lfsr_trace_message_checker_core.sv
verif/tb_top.sv
